### rtl/mbmm_pkg.sv
// Shared types, address map constants and helper functions of the main bus decoder.
package mbmm_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned SCROLL_W    = 9;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam int unsigned ROM_DEPTH  = 49152;
   localparam int unsigned VRAM_DEPTH = 2048;
   localparam int unsigned WRAM_DEPTH = 8192;
   localparam int unsigned ROM_IDX_W  = $clog2(ROM_DEPTH);
   localparam int unsigned VRAM_IDX_W = $clog2(VRAM_DEPTH);
   localparam int unsigned WRAM_IDX_W = $clog2(WRAM_DEPTH);

   localparam logic [ADDR_W-1:0] ROM_TOP      = 16'hBFFF;
   localparam logic [ADDR_W-1:0] IN0_ADDR     = 16'hC000;
   localparam logic [ADDR_W-1:0] IN1_ADDR     = 16'hC001;
   localparam logic [ADDR_W-1:0] IN2_ADDR     = 16'hC002;
   localparam logic [ADDR_W-1:0] DIPA_ADDR    = 16'hC003;
   localparam logic [ADDR_W-1:0] DIPB_ADDR    = 16'hC004;
   localparam logic [ADDR_W-1:0] LATCH_ADDR   = 16'hC800;
   localparam logic [ADDR_W-1:0] CTRL_ADDR    = 16'hC804;
   localparam logic [ADDR_W-1:0] SCRY_LO_ADDR = 16'hC808;
   localparam logic [ADDR_W-1:0] SCRY_HI_ADDR = 16'hC809;
   localparam logic [ADDR_W-1:0] SCRX_LO_ADDR = 16'hC80A;
   localparam logic [ADDR_W-1:0] SCRX_HI_ADDR = 16'hC80B;
   localparam logic [ADDR_W-1:0] CHAR_BASE    = 16'hD000;
   localparam logic [ADDR_W-1:0] CHAR_TOP     = 16'hD7FF;
   localparam logic [ADDR_W-1:0] TILE_BASE    = 16'hD800;
   localparam logic [ADDR_W-1:0] TILE_TOP     = 16'hDFFF;
   localparam logic [ADDR_W-1:0] WORK_BASE    = 16'hE000;

   localparam int unsigned HOLD_BIT = 4;
   localparam int unsigned FLIP_BIT = 7;

   localparam logic [DATA_W-1:0] OPEN_BUS  = 8'hFF;
   localparam logic [DATA_W-1:0] DIP_RESET = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_A = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_B = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_FETCH = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_LOAD  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      REGION_ROM,
      REGION_IN0,
      REGION_IN1,
      REGION_IN2,
      REGION_DIPA,
      REGION_DIPB,
      REGION_CHAR,
      REGION_TILE,
      REGION_WORK,
      REGION_NONE
   } region_type;

   typedef enum logic [1:0] {
      MEM_ROM,
      MEM_CHAR,
      MEM_TILE,
      MEM_WORK
   } mem_sel_type;

   typedef struct packed {
      logic                rd;
      logic                wr;
      mem_sel_type         sel;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   wdata;
   } mem_req_type;

   typedef struct packed {
      logic [SCROLL_W-1:0] scroll_x;
      logic [SCROLL_W-1:0] scroll_y;
      logic [DATA_W-1:0]   latch;
      logic                flip;
      logic                hold;
   } ctrl_state_type;

   function automatic region_type decode_region(input logic [ADDR_W-1:0] a);
      region_type r;
      if (a <= ROM_TOP)                          r = REGION_ROM;
      else if (a == IN0_ADDR)                    r = REGION_IN0;
      else if (a == IN1_ADDR)                    r = REGION_IN1;
      else if (a == IN2_ADDR)                    r = REGION_IN2;
      else if (a == DIPA_ADDR)                   r = REGION_DIPA;
      else if (a == DIPB_ADDR)                   r = REGION_DIPB;
      else if (a >= CHAR_BASE && a <= CHAR_TOP)  r = REGION_CHAR;
      else if (a >= TILE_BASE && a <= TILE_TOP)  r = REGION_TILE;
      else if (a >= WORK_BASE)                   r = REGION_WORK;
      else                                       r = REGION_NONE;
      return r;
   endfunction

   // Opcode scramble: result bits 7..0 are stored bits 3,2,1,4,7,6,5,0.
   function automatic logic [DATA_W-1:0] permute_opcode(input logic [DATA_W-1:0] v);
      return {v[3], v[2], v[1], v[4], v[7], v[6], v[5], v[0]};
   endfunction

endpackage

### rtl/mbmm_mem_bank.sv
// Program ROM, character RAM, tile RAM and work RAM with registered read data.
module mbmm_mem_bank
   import mbmm_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] rom_mem  [ROM_DEPTH];
   logic [DATA_W-1:0] char_mem [VRAM_DEPTH];
   logic [DATA_W-1:0] tile_mem [VRAM_DEPTH];
   logic [DATA_W-1:0] work_mem [WRAM_DEPTH];

   logic [DATA_W-1:0] rom_rd_ff;
   logic [DATA_W-1:0] char_rd_ff;
   logic [DATA_W-1:0] tile_rd_ff;
   logic [DATA_W-1:0] work_rd_ff;
   mem_sel_type       sel_ff;

   logic [ROM_IDX_W-1:0]  rom_idx;
   logic [VRAM_IDX_W-1:0] vram_idx;
   logic [WRAM_IDX_W-1:0] wram_idx;

   assign rom_idx  = mem_req.addr[ROM_IDX_W-1:0];
   assign vram_idx = mem_req.addr[VRAM_IDX_W-1:0];
   assign wram_idx = mem_req.addr[WRAM_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_req.wr && mem_req.sel == MEM_ROM) begin
         rom_mem[rom_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && mem_req.sel == MEM_ROM) begin
         rom_rd_ff <= rom_mem[rom_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr && mem_req.sel == MEM_CHAR) begin
         char_mem[vram_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && mem_req.sel == MEM_CHAR) begin
         char_rd_ff <= char_mem[vram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr && mem_req.sel == MEM_TILE) begin
         tile_mem[vram_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && mem_req.sel == MEM_TILE) begin
         tile_rd_ff <= tile_mem[vram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr && mem_req.sel == MEM_WORK) begin
         work_mem[wram_idx] <= mem_req.wdata;
      end
      if (mem_req.rd && mem_req.sel == MEM_WORK) begin
         work_rd_ff <= work_mem[wram_idx];
      end
   end

   // Remember which store answered the last read.
   always_ff @(posedge clock) begin
      if (mem_req.rd) begin
         sel_ff <= mem_req.sel;
      end
   end

   always_comb begin
      unique case (sel_ff)
         MEM_ROM:  rdata = rom_rd_ff;
         MEM_CHAR: rdata = char_rd_ff;
         MEM_TILE: rdata = tile_rd_ff;
         MEM_WORK: rdata = work_rd_ff;
         default:  rdata = rom_rd_ff;
      endcase
   end

endmodule

### rtl/mbmm_ctrl_regs.sv
// Scroll, sound latch, flip and hold registers plus the DIP switch registers.
module mbmm_ctrl_regs
   import mbmm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      addr,
   input  logic [DATA_W-1:0]      wdata,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_write_data,
   output ctrl_state_type         post_state,
   output logic                   release_pulse,
   output logic [DATA_W-1:0]      dip_a,
   output logic [DATA_W-1:0]      dip_b
);

   ctrl_state_type    state_ff, state_in;
   logic [DATA_W-1:0] dip_a_ff, dip_a_in;
   logic [DATA_W-1:0] dip_b_ff, dip_b_in;

   always_comb begin
      state_in      = state_ff;
      release_pulse = 1'b0;
      if (wr_en) begin
         unique case (addr)
            LATCH_ADDR: state_in.latch = wdata;
            CTRL_ADDR: begin
               state_in.hold = wdata[HOLD_BIT];
               state_in.flip = wdata[FLIP_BIT];
               release_pulse = state_ff.hold && !wdata[HOLD_BIT];
            end
            SCRY_LO_ADDR: state_in.scroll_y = {state_ff.scroll_y[SCROLL_W-1], wdata};
            SCRY_HI_ADDR: state_in.scroll_y = {wdata[0], state_ff.scroll_y[SCROLL_W-2:0]};
            SCRX_LO_ADDR: state_in.scroll_x = {state_ff.scroll_x[SCROLL_W-1], wdata};
            SCRX_HI_ADDR: state_in.scroll_x = {wdata[0], state_ff.scroll_x[SCROLL_W-2:0]};
            default: ;
         endcase
      end
   end

   always_comb begin
      dip_a_in = dip_a_ff;
      dip_b_in = dip_b_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DIP_A: dip_a_in = csr_write_data;
            CSR_DIP_B: dip_b_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{scroll_x: '0, scroll_y: '0, latch: '0, flip: 1'b0, hold: 1'b1};
         dip_a_ff <= DIP_RESET;
         dip_b_ff <= DIP_RESET;
      end else begin
         state_ff <= state_in;
         dip_a_ff <= dip_a_in;
         dip_b_ff <= dip_b_in;
      end
   end

   assign post_state = state_in;
   assign dip_a      = dip_a_ff;
   assign dip_b      = dip_b_ff;

endmodule

### rtl/main_bus_memory_map.sv
// Top level of the main bus decoder: request pipeline, memories and control registers.
//
// One bus request per cycle: a data read, an opcode fetch, a write or a program ROM
// load. Each request gives exactly one response carrying the read byte and the
// scroll, sound latch, flip and hold state after that request. The accept edge loads the
// memory stage and the synchronous read of the ROM or RAM; the output register is loaded
// when the memory stage advances, and the response is then valid. Throughput is one
// request per cycle while the response side keeps up; a stalled response holds the
// pipeline, and a new request is taken as soon as the memory stage can move on.
// Stores are not cleared at reset.
module main_bus_memory_map
   import mbmm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  logic [ADDR_W-1:0]      req_address,
   input  logic [DATA_W-1:0]      req_write_data,
   input  logic [DATA_W-1:0]      req_port_start_coin,
   input  logic [DATA_W-1:0]      req_port_player_one,
   input  logic [DATA_W-1:0]      req_port_player_two,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DATA_W-1:0]      rsp_read_data,
   output logic [SCROLL_W-1:0]    rsp_scroll_x_value,
   output logic [SCROLL_W-1:0]    rsp_scroll_y_value,
   output logic [DATA_W-1:0]      rsp_sound_latch,
   output logic                   rsp_flip_flag,
   output logic                   rsp_sound_held,
   output logic                   rsp_sound_reset_pulse,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_write_data
);

   typedef struct packed {
      logic              from_mem;
      logic              permute;
      logic [DATA_W-1:0] imm;
      ctrl_state_type    ctrl;
      logic              pulse;
   } stage_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      ctrl_state_type    ctrl;
      logic              pulse;
   } rsp_type;

   logic           accept;
   logic           b_advance;
   logic           b_valid_ff, b_valid_in;
   stage_type      b_ff, b_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;

   kind_type          kind;
   region_type        region;
   logic              is_read;
   logic              mem_region;
   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;
   ctrl_state_type    post_state;
   logic              release_pulse;
   logic [DATA_W-1:0] dip_a;
   logic [DATA_W-1:0] dip_b;
   logic [DATA_W-1:0] imm_byte;
   logic [DATA_W-1:0] mem_byte;

   assign kind   = kind_type'(req_kind);
   assign region = decode_region(req_address);

   assign b_advance = b_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !b_valid_ff || b_advance;
   assign accept    = req_valid && req_ready;

   assign is_read    = (kind == KIND_READ) || (kind == KIND_FETCH);
   assign mem_region = (region == REGION_ROM) || (region == REGION_CHAR) ||
                       (region == REGION_TILE) || (region == REGION_WORK);

   always_comb begin
      mem_req.rd    = accept && is_read && mem_region;
      mem_req.wr    = accept && (((kind == KIND_WRITE) && mem_region && (region != REGION_ROM))
                                 || ((kind == KIND_LOAD) && (region == REGION_ROM)));
      mem_req.addr  = req_address;
      mem_req.wdata = req_write_data;
      case (region)
         REGION_CHAR: mem_req.sel = MEM_CHAR;
         REGION_TILE: mem_req.sel = MEM_TILE;
         REGION_WORK: mem_req.sel = MEM_WORK;
         default:     mem_req.sel = MEM_ROM;
      endcase
   end

   mbmm_mem_bank u_mem_bank (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   mbmm_ctrl_regs u_ctrl_regs (
      .clock            (clock),
      .reset            (reset),
      .wr_en            (accept && (kind == KIND_WRITE)),
      .addr             (req_address),
      .wdata            (req_write_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .post_state       (post_state),
      .release_pulse    (release_pulse),
      .dip_a            (dip_a),
      .dip_b            (dip_b)
   );

   // Bytes that do not come from a store are settled at accept.
   always_comb begin
      if (!is_read) begin
         imm_byte = '0;
      end else begin
         case (region)
            REGION_IN0:  imm_byte = req_port_start_coin;
            REGION_IN1:  imm_byte = req_port_player_one;
            REGION_IN2:  imm_byte = req_port_player_two;
            REGION_DIPA: imm_byte = dip_a;
            REGION_DIPB: imm_byte = dip_b;
            default:     imm_byte = OPEN_BUS;
         endcase
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_in       = b_ff;
      if (accept) begin
         b_valid_in    = 1'b1;
         b_in.from_mem = is_read && mem_region;
         b_in.permute  = (kind == KIND_FETCH) && (region == REGION_ROM) && (req_address != '0);
         b_in.imm      = imm_byte;
         b_in.ctrl     = post_state;
         b_in.pulse    = release_pulse;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
   end

   assign mem_byte = b_ff.permute ? permute_opcode(mem_rdata) : mem_rdata;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (b_advance) begin
         out_valid_in     = 1'b1;
         out_in.read_data = b_ff.from_mem ? mem_byte : b_ff.imm;
         out_in.ctrl      = b_ff.ctrl;
         out_in.pulse     = b_ff.pulse;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
      b_ff   <= b_in;
      out_ff <= out_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_read_data         = out_ff.read_data;
   assign rsp_scroll_x_value    = out_ff.ctrl.scroll_x;
   assign rsp_scroll_y_value    = out_ff.ctrl.scroll_y;
   assign rsp_sound_latch       = out_ff.ctrl.latch;
   assign rsp_flip_flag         = out_ff.ctrl.flip;
   assign rsp_sound_held        = out_ff.ctrl.hold;
   assign rsp_sound_reset_pulse = out_ff.pulse;

`ifndef SYNTHESIS
   a_pulse_clears_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sound_reset_pulse |-> !rsp_sound_held)
      else $error("sound reset pulse with hold still set");

   a_stage_kept: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_advance |=> b_valid_ff && $stable(b_ff))
      else $error("memory stage lost or changed while stalled");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      accept |-> !b_valid_ff || b_advance)
      else $error("request accepted over a stalled memory stage");

   a_stage_feeds_out: assert property (@(posedge clock) disable iff (reset)
      b_advance |=> out_valid_ff)
      else $error("memory stage advanced without a response");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the main bus decoder: directed and random bus traffic checked against a predictor.
module tb
   import mbmm_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT      = 500000;
   localparam int unsigned RANDOM_PER_PHASE = 400;
   localparam int unsigned MAX_PAUSE        = 9;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   wdata;
      logic [DATA_W-1:0]   start_coin;
      logic [DATA_W-1:0]   player_one;
      logic [DATA_W-1:0]   player_two;
   } bus_access_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [SCROLL_W-1:0] scroll_x;
      logic [SCROLL_W-1:0] scroll_y;
      logic [DATA_W-1:0]   latch;
      logic                flip;
      logic                held;
      logic                pulse;
   } bus_response_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_kind = '0;
   logic [ADDR_W-1:0]      req_address = '0;
   logic [DATA_W-1:0]      req_write_data = '0;
   logic [DATA_W-1:0]      req_port_start_coin = '0;
   logic [DATA_W-1:0]      req_port_player_one = '0;
   logic [DATA_W-1:0]      req_port_player_two = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [DATA_W-1:0]      rsp_read_data;
   logic [SCROLL_W-1:0]    rsp_scroll_x_value;
   logic [SCROLL_W-1:0]    rsp_scroll_y_value;
   logic [DATA_W-1:0]      rsp_sound_latch;
   logic                   rsp_flip_flag;
   logic                   rsp_sound_held;
   logic                   rsp_sound_reset_pulse;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]      csr_write_data = '0;

   // requests waiting to be driven, responses waiting to arrive
   bus_access_type   accesses_pending[$];
   bus_response_type responses_due[$];

   // predicted state of the decoder
   logic [DATA_W-1:0]   shadow_rom  [0:ROM_DEPTH-1];
   logic [DATA_W-1:0]   shadow_char [0:VRAM_DEPTH-1];
   logic [DATA_W-1:0]   shadow_tile [0:VRAM_DEPTH-1];
   logic [DATA_W-1:0]   shadow_work [0:WRAM_DEPTH-1];
   logic [SCROLL_W-1:0] shadow_scroll_x = '0;
   logic [SCROLL_W-1:0] shadow_scroll_y = '0;
   logic [DATA_W-1:0]   shadow_latch = '0;
   logic                shadow_flip = 1'b0;
   logic                shadow_hold = 1'b1;
   logic [DATA_W-1:0]   shadow_dip_a = DIP_RESET;
   logic [DATA_W-1:0]   shadow_dip_b = DIP_RESET;

   // store cells already written by generated traffic, indexed by bus address
   bit                  store_written [0:65535];
   logic [ADDR_W-1:0]   rom_written_q[$];
   logic [ADDR_W-1:0]   ram_written_q[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   bit          req_sent = 1'b0;
   bit          rsp_taken = 1'b0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;

   main_bus_memory_map u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_address           (req_address),
      .req_write_data        (req_write_data),
      .req_port_start_coin   (req_port_start_coin),
      .req_port_player_one   (req_port_player_one),
      .req_port_player_two   (req_port_player_two),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_scroll_x_value    (rsp_scroll_x_value),
      .rsp_scroll_y_value    (rsp_scroll_y_value),
      .rsp_sound_latch       (rsp_sound_latch),
      .rsp_flip_flag         (rsp_flip_flag),
      .rsp_sound_held        (rsp_sound_held),
      .rsp_sound_reset_pulse (rsp_sound_reset_pulse),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   function automatic logic [DATA_W-1:0] scramble_byte(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      r[7] = v[3];
      r[6] = v[2];
      r[5] = v[1];
      r[4] = v[4];
      r[3] = v[7];
      r[2] = v[6];
      r[1] = v[5];
      r[0] = v[0];
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] peek_byte(input bus_access_type acc);
      logic [ADDR_W-1:0] a;
      a = acc.address;
      if (a <= ROM_TOP) return shadow_rom[a];
      if (a == IN0_ADDR) return acc.start_coin;
      if (a == IN1_ADDR) return acc.player_one;
      if (a == IN2_ADDR) return acc.player_two;
      if (a == DIPA_ADDR) return shadow_dip_a;
      if (a == DIPB_ADDR) return shadow_dip_b;
      if (a >= CHAR_BASE && a <= CHAR_TOP) return shadow_char[a[10:0]];
      if (a >= TILE_BASE && a <= TILE_TOP) return shadow_tile[a[10:0]];
      if (a >= WORK_BASE) return shadow_work[a[12:0]];
      return OPEN_BUS;
   endfunction

   // Apply one bus access to the predicted state and return the response it gives.
   function automatic bus_response_type model_bus_access(input bus_access_type acc);
      bus_response_type rsp;
      logic [ADDR_W-1:0] a;
      rsp = '0;
      a = acc.address;
      case (acc.kind)
         KIND_READ: rsp.read_data = peek_byte(acc);
         KIND_FETCH: begin
            // the byte at address zero is never scrambled
            if (a <= ROM_TOP && a != '0)
               rsp.read_data = scramble_byte(shadow_rom[a]);
            else
               rsp.read_data = peek_byte(acc);
         end
         KIND_WRITE: begin
            if (a == LATCH_ADDR) begin
               shadow_latch = acc.wdata;
            end else if (a == CTRL_ADDR) begin
               rsp.pulse = shadow_hold & ~acc.wdata[HOLD_BIT];
               shadow_hold = acc.wdata[HOLD_BIT];
               shadow_flip = acc.wdata[FLIP_BIT];
            end else if (a == SCRY_LO_ADDR) begin
               shadow_scroll_y[7:0] = acc.wdata;
            end else if (a == SCRY_HI_ADDR) begin
               shadow_scroll_y[8] = acc.wdata[0];
            end else if (a == SCRX_LO_ADDR) begin
               shadow_scroll_x[7:0] = acc.wdata;
            end else if (a == SCRX_HI_ADDR) begin
               shadow_scroll_x[8] = acc.wdata[0];
            end else if (a >= CHAR_BASE && a <= CHAR_TOP) begin
               shadow_char[a[10:0]] = acc.wdata;
            end else if (a >= TILE_BASE && a <= TILE_TOP) begin
               shadow_tile[a[10:0]] = acc.wdata;
            end else if (a >= WORK_BASE) begin
               shadow_work[a[12:0]] = acc.wdata;
            end
         end
         default: begin
            if (a <= ROM_TOP) shadow_rom[a] = acc.wdata;
         end
      endcase
      rsp.scroll_x = shadow_scroll_x;
      rsp.scroll_y = shadow_scroll_y;
      rsp.latch    = shadow_latch;
      rsp.flip     = shadow_flip;
      rsp.held     = shadow_hold;
      return rsp;
   endfunction

   function automatic logic [DATA_W-1:0] rand_byte();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic int unsigned draw_pause(input bit quiet);
      return quiet ? 0 : $urandom_range(0, MAX_PAUSE);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task automatic queue_access(input kind_type kind, input logic [ADDR_W-1:0] address,
                               input logic [DATA_W-1:0] wdata);
      bus_access_type acc;
      bit             in_store;
      in_store = (address <= ROM_TOP) || (address >= CHAR_BASE);
      acc.kind       = kind;
      acc.address    = address;
      acc.wdata      = wdata;
      acc.start_coin = rand_byte();
      acc.player_one = rand_byte();
      acc.player_two = rand_byte();
      // never read a store cell that holds nothing yet: turn it into a write
      if ((kind == KIND_READ || kind == KIND_FETCH) && in_store && !store_written[address])
         acc.kind = KIND_WRITE;
      if ((acc.kind == KIND_LOAD && address <= ROM_TOP) ||
          (acc.kind == KIND_WRITE && address >= CHAR_BASE)) begin
         if (!store_written[address]) begin
            store_written[address] = 1'b1;
            if (address <= ROM_TOP) rom_written_q = {rom_written_q, address};
            else ram_written_q = {ram_written_q, address};
         end
      end
      accesses_pending = {accesses_pending, acc};
   endtask

   task automatic queue_random_access();
      int unsigned       pick;
      logic [ADDR_W-1:0] target;
      kind_type          look;
      pick = $urandom_range(0, 99);
      look = ($urandom_range(0, 1) == 0) ? KIND_READ : KIND_FETCH;
      if (pick < 15) begin
         case ($urandom_range(0, 15))
            0:       target = '0;
            1:       target = ROM_TOP;
            default: target = ADDR_W'($urandom_range(0, ROM_TOP));
         endcase
         queue_access(KIND_LOAD, target, rand_byte());
      end else if (pick < 18) begin
         queue_access(KIND_LOAD, ADDR_W'($urandom_range(IN0_ADDR, 16'hFFFF)), rand_byte());
      end else if (pick < 46 && rom_written_q.size() != 0) begin
         target = rom_written_q[$urandom_range(0, rom_written_q.size() - 1)];
         queue_access(pick < 33 ? KIND_READ : KIND_FETCH, target, rand_byte());
      end else if (pick < 52) begin
         queue_access(look, ADDR_W'(IN0_ADDR + $urandom_range(0, 4)), rand_byte());
      end else if (pick < 56) begin
         queue_access(look, ADDR_W'($urandom_range(DIPB_ADDR + 1, CHAR_BASE - 1)),
                      rand_byte());
      end else if (pick < 68) begin
         case ($urandom_range(0, 5))
            0:       target = LATCH_ADDR;
            1:       target = SCRY_LO_ADDR;
            2:       target = SCRY_HI_ADDR;
            3:       target = SCRX_LO_ADDR;
            4:       target = SCRX_HI_ADDR;
            default: target = CTRL_ADDR;
         endcase
         queue_access(KIND_WRITE, target, rand_byte());
      end else if (pick < 80) begin
         queue_access(KIND_WRITE, ADDR_W'($urandom_range(CHAR_BASE, 16'hFFFF)), rand_byte());
      end else if (pick < 92 && ram_written_q.size() != 0) begin
         target = ram_written_q[$urandom_range(0, ram_written_q.size() - 1)];
         queue_access(look, target, rand_byte());
      end else if (pick < 96) begin
         // writes that must change nothing
         case ($urandom_range(0, 2))
            0:       target = ADDR_W'($urandom_range(0, ROM_TOP));
            1:       target = ADDR_W'($urandom_range(IN0_ADDR, LATCH_ADDR - 1));
            default: target = ADDR_W'($urandom_range(SCRX_HI_ADDR + 1, CHAR_BASE - 1));
         endcase
         queue_access(KIND_WRITE, target, rand_byte());
      end else begin
         queue_access(kind_type'($urandom_range(0, 3)), ADDR_W'($urandom_range(0, 16'hFFFF)),
                      rand_byte());
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_DIP_A) shadow_dip_a = value;
      else shadow_dip_b = value;
   endtask

   // Hold off until every request is out and every response is back.
   task automatic drain();
      while (accesses_pending.size() != 0 || responses_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_sent) begin
         if (req_sent) begin
            req_sent = 1'b0;
            if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
            req_gap = draw_pause(req_quiet);
         end
         if (req_gap == 0 && accesses_pending.size() != 0) begin
            req_valid           <= 1'b1;
            req_kind            <= accesses_pending[0].kind;
            req_address         <= accesses_pending[0].address;
            req_write_data      <= accesses_pending[0].wdata;
            req_port_start_coin <= accesses_pending[0].start_coin;
            req_port_player_one <= accesses_pending[0].player_one;
            req_port_player_two <= accesses_pending[0].player_two;
         end else begin
            req_valid <= 1'b0;
            if (req_gap != 0) req_gap--;
         end
      end
   end

   always @(negedge clock) begin : response_stall
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
            rsp_stall = draw_pause(rsp_quiet);
         end
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      bus_access_type   seen;
      bus_response_type got;
      bus_response_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken     = 1'b1;
            got.read_data = rsp_read_data;
            got.scroll_x  = rsp_scroll_x_value;
            got.scroll_y  = rsp_scroll_y_value;
            got.latch     = rsp_sound_latch;
            got.flip      = rsp_flip_flag;
            got.held      = rsp_sound_held;
            got.pulse     = rsp_sound_reset_pulse;
            if (responses_due.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = responses_due.pop_front();
               check_field("read_data", 16'(got.read_data), 16'(want.read_data));
               check_field("scroll_x_value", 16'(got.scroll_x), 16'(want.scroll_x));
               check_field("scroll_y_value", 16'(got.scroll_y), 16'(want.scroll_y));
               check_field("sound_latch", 16'(got.latch), 16'(want.latch));
               check_field("flip_flag", 16'(got.flip), 16'(want.flip));
               check_field("sound_held", 16'(got.held), 16'(want.held));
               check_field("sound_reset_pulse", 16'(got.pulse), 16'(want.pulse));
            end
         end
         if (req_valid && req_ready) begin
            req_sent        = 1'b1;
            seen.kind       = kind_type'(req_kind);
            seen.address    = req_address;
            seen.wdata      = req_write_data;
            seen.start_coin = req_port_start_coin;
            seen.player_one = req_port_player_one;
            seen.player_two = req_port_player_two;
            responses_due = {responses_due, model_bus_access(seen)};
            void'(accesses_pending.pop_front());
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [DATA_W-1:0] dip_a;
      logic [DATA_W-1:0] dip_b;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: DIP reset values, ROM bounds, scramble, ports, unmapped, control, RAMs
      queue_access(KIND_READ, DIPA_ADDR, 8'h00);
      queue_access(KIND_READ, DIPB_ADDR, 8'h00);
      queue_access(KIND_LOAD, 16'h0000, 8'hA5);
      queue_access(KIND_LOAD, ROM_TOP, 8'h3C);
      queue_access(KIND_LOAD, 16'h1234, 8'h96);
      queue_access(KIND_LOAD, IN0_ADDR, 8'h11);
      queue_access(KIND_FETCH, 16'h0000, 8'h00);
      queue_access(KIND_FETCH, ROM_TOP, 8'h00);
      queue_access(KIND_FETCH, 16'h1234, 8'h00);
      queue_access(KIND_WRITE, 16'h1234, 8'h00);
      queue_access(KIND_READ, 16'h1234, 8'h00);
      queue_access(KIND_READ, IN0_ADDR, 8'h00);
      queue_access(KIND_FETCH, IN2_ADDR, 8'h00);
      queue_access(KIND_READ, DIPB_ADDR + 1, 8'h00);
      queue_access(KIND_FETCH, LATCH_ADDR, 8'h00);
      queue_access(KIND_WRITE, LATCH_ADDR, 8'h5A);
      queue_access(KIND_WRITE, CTRL_ADDR, 8'h90);
      queue_access(KIND_WRITE, CTRL_ADDR, 8'h00);
      queue_access(KIND_WRITE, CTRL_ADDR, 8'h10);
      queue_access(KIND_WRITE, SCRY_HI_ADDR, 8'h01);
      queue_access(KIND_WRITE, SCRY_LO_ADDR, 8'hFF);
      queue_access(KIND_WRITE, SCRX_HI_ADDR, 8'hFF);
      queue_access(KIND_WRITE, 16'hFFFF, 8'h77);
      queue_access(KIND_LOAD, 16'hFFFF, 8'h88);
      queue_access(KIND_READ, 16'hFFFF, 8'h00);
      queue_access(KIND_WRITE, CHAR_BASE, 8'h01);
      queue_access(KIND_WRITE, TILE_TOP, 8'hFE);
      queue_access(KIND_FETCH, CHAR_BASE, 8'h00);
      queue_access(KIND_READ, TILE_TOP, 8'h00);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               dip_a = 8'h00;
               dip_b = 8'hFF;
            end
            1: begin
               dip_a = 8'hFF;
               dip_b = 8'h00;
            end
            2: begin
               dip_a = DATA_W'($urandom_range(0, 255));
               dip_b = DATA_W'($urandom_range(0, 255));
            end
            default: begin
               dip_a = 8'h5A;
               dip_b = 8'hA5;
            end
         endcase
         write_csr(CSR_DIP_A, dip_a);
         write_csr(CSR_DIP_B, dip_b);
         @(posedge clock);
         queue_access(KIND_READ, DIPA_ADDR, 8'h00);
         queue_access(KIND_FETCH, DIPB_ADDR, 8'h00);
         repeat (RANDOM_PER_PHASE) queue_random_access();
         drain();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
